// File: rtl/windowed_pi_differential_motor_mix_macros.svh
// Assertion macros shared by the windowed PI motor mix RTL.
`ifndef WINDOWED_PI_DIFFERENTIAL_MOTOR_MIX_MACROS_SVH
`define WINDOWED_PI_DIFFERENTIAL_MOTOR_MIX_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define WPDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define WPDM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define WPDM_ASSERT(lbl, prop, msg)
`define WPDM_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// File: rtl/wpdm_pkg.sv
// Shared types, widths and constants for the windowed PI motor mix.
package wpdm_pkg;

  localparam int ANGLE_W = 17;
  localparam int ERR_W   = ANGLE_W + 1;
  localparam int ABS_W   = ANGLE_W;
  localparam int GAIN_W  = 16;
  localparam int WIN_W   = 16;
  localparam int PULSE_W = 12;
  localparam int ISUM_W  = 32;
  localparam int PROD_W  = 35;
  localparam int SUM_W   = PROD_W + 1;
  localparam int TOT_W   = SUM_W + 1;
  localparam int FRAC_W  = 20;
  localparam int CORR_W  = TOT_W - FRAC_W;
  localparam int MIX_W   = CORR_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ANGLE_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [GAIN_W-1:0]         PROP_GAIN_RST  = 16'd2048;
  localparam logic [GAIN_W-1:0]         INTEG_GAIN_RST = 16'd307;
  localparam logic signed [ANGLE_W-1:0] TARGET_RST     = 17'sd1536;
  localparam logic [WIN_W-1:0]          WINDOW_RST     = 16'd512;
  localparam logic [PULSE_W-1:0]        BASE_RST       = 12'd1275;
  localparam logic [PULSE_W-1:0]        PMIN_RST       = 12'd1100;
  localparam logic [PULSE_W-1:0]        PMAX_RST       = 12'd1450;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_TARGET     = 3'd2,
    REG_WINDOW     = 3'd3,
    REG_BASE       = 3'd4,
    REG_PMIN       = 3'd5,
    REG_PMAX       = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         integ_gain;
    logic signed [ANGLE_W-1:0] target_angle;
    logic [WIN_W-1:0]          integ_window;
    logic [PULSE_W-1:0]        base_pulse;
    logic [PULSE_W-1:0]        pulse_min;
    logic [PULSE_W-1:0]        pulse_max;
  } cfg_t;

  // One classified sample as it travels from front to back.
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    integ;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/wpdm_front.sv
// Front end: takes pitch samples, forms the error and the window decision.
`include "windowed_pi_differential_motor_mix_macros.svh"

module wpdm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wpdm_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [wpdm_pkg::ANGLE_W-1:0] in_pitch,
  input  wpdm_pkg::q_stat_t                q_stat,
  output logic                             push,
  output wpdm_pkg::item_t                  push_item
);
  import wpdm_pkg::*;

  logic                    fr_vld_r, fr_vld_nxt;
  item_t                   fr_item_r, fr_item_nxt;
  logic signed [ERR_W-1:0] err;
  logic        [ERR_W-1:0] abs_err;

  assign push     = fr_vld_r && !q_stat.full;
  assign in_stall = fr_vld_r && q_stat.full;

  always_comb begin
    err = {in_pitch[ANGLE_W-1], in_pitch} - {cfg.target_angle[ANGLE_W-1], cfg.target_angle};
    abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    fr_item_nxt.err   = err;
    // The magnitude never exceeds 2^17 - 1, so the top bit is always clear.
    fr_item_nxt.integ = abs_err[ABS_W-1:0] < {1'b0, cfg.integ_window};
  end

  always_comb begin
    fr_vld_nxt = fr_vld_r;
    if (!in_stall) begin
      fr_vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      fr_item_r <= fr_item_nxt;
    end
  end

  assign push_item = fr_item_r;

  `WPDM_ASSERT(a_stall_needs_item, in_stall |-> fr_vld_r, "front stalls with no held item")

endmodule

// File: rtl/wpdm_queue.sv
// Short queue that decouples the front end from the arithmetic back end.
`include "windowed_pi_differential_motor_mix_macros.svh"

module wpdm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wpdm_pkg::item_t   push_item,
  input  logic              pop,
  output wpdm_pkg::item_t   pop_item,
  output wpdm_pkg::q_stat_t q_stat
);
  import wpdm_pkg::*;

  item_t             mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

  `WPDM_ASSERT(a_count_bound, count_r <= Q_CW'(Q_DEPTH), "queue count beyond depth")
  `WPDM_ASSERT_NEVER(a_pop_empty, pop && q_stat.empty, "pop from an empty queue")

endmodule

// File: rtl/wpdm_back.sv
// Back end: gain products, windowed integral, rounding and motor mix.
`include "windowed_pi_differential_motor_mix_macros.svh"

module wpdm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wpdm_pkg::cfg_t                     cfg,
  input  wpdm_pkg::item_t                    pop_item,
  input  wpdm_pkg::q_stat_t                  q_stat,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [wpdm_pkg::PULSE_W-1:0]       out_left_pulse,
  output logic [wpdm_pkg::PULSE_W-1:0]       out_right_pulse,
  output logic                               out_integrating
);
  import wpdm_pkg::*;

  localparam logic signed [TOT_W-1:0] ROUND_HALF = TOT_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] ISUM_MAX   = SUM_W'((64'sd1 <<< (ISUM_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] ISUM_MIN   = -(SUM_W'(64'sd1 <<< (ISUM_W - 1)));

  logic adv;
  logic integ_upd;

  // Stage 1: products.
  logic                     s1_vld_r;
  logic                     s1_integ_r;
  logic signed [PROD_W-1:0] s1_pprod_r, s1_iprod_r;
  logic signed [PROD_W-1:0] pgain_x, igain_x, err_x;

  // Stage 2: proportional term and updated integral.
  logic                     s2_vld_r;
  logic                     s2_integ_r;
  logic signed [PROD_W-1:0] s2_pterm_r;
  logic signed [ISUM_W-1:0] integ_sum_r, integ_sum_nxt;
  logic signed [SUM_W-1:0]  isum_wide;

  // Stage 3: rounded correction.
  logic                     s3_vld_r;
  logic                     s3_integ_r;
  logic signed [CORR_W-1:0] s3_corr_r, corr_nxt;
  logic signed [TOT_W-1:0]  total;

  // Output register.
  logic                     out_vld_r;
  logic                     out_integ_r;
  logic [PULSE_W-1:0]       out_left_r, out_right_r, left_nxt, right_nxt;
  logic signed [MIX_W-1:0]  base_x, corr_x, left_raw, right_raw;

  function automatic logic [PULSE_W-1:0] clamp_pulse(
    input logic signed [MIX_W-1:0] p,
    input logic [PULSE_W-1:0]      lo,
    input logic [PULSE_W-1:0]      hi
  );
    logic signed [MIX_W-1:0] v;
    logic signed [MIX_W-1:0] lo_x;
    logic signed [MIX_W-1:0] hi_x;
    lo_x = $signed({{(MIX_W-PULSE_W){1'b0}}, lo});
    hi_x = $signed({{(MIX_W-PULSE_W){1'b0}}, hi});
    v = p;
    // Raise to the floor first, then cut to the ceiling, so inverted limits give the ceiling.
    if (v < lo_x) begin
      v = lo_x;
    end
    if (v > hi_x) begin
      v = hi_x;
    end
    return v[PULSE_W-1:0];
  endfunction

  // Every stage moves together whenever the output register can take a new result.
  assign adv       = !out_vld_r || !out_stall;
  assign pop       = adv && !q_stat.empty;
  assign integ_upd = adv && s1_vld_r && s1_integ_r;

  always_comb begin
    pgain_x = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.prop_gain});
    igain_x = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.integ_gain});
    err_x   = {{(PROD_W-ERR_W){pop_item.err[ERR_W-1]}}, pop_item.err};
  end

  always_comb begin
    isum_wide = {{(SUM_W-ISUM_W){integ_sum_r[ISUM_W-1]}}, integ_sum_r}
              + {s1_iprod_r[PROD_W-1], s1_iprod_r};
    priority if (isum_wide > ISUM_MAX) begin
      integ_sum_nxt = ISUM_W'(ISUM_MAX);
    end else if (isum_wide < ISUM_MIN) begin
      integ_sum_nxt = ISUM_W'(ISUM_MIN);
    end else begin
      integ_sum_nxt = isum_wide[ISUM_W-1:0];
    end
  end

  always_comb begin
    total = {{(TOT_W-PROD_W){s2_pterm_r[PROD_W-1]}}, s2_pterm_r}
          + {{(TOT_W-ISUM_W){integ_sum_r[ISUM_W-1]}}, integ_sum_r}
          + ROUND_HALF;
    // Arithmetic shift floors, which gives round half up.
    corr_nxt = total[TOT_W-1:FRAC_W];
  end

  always_comb begin
    base_x    = $signed({{(MIX_W-PULSE_W){1'b0}}, cfg.base_pulse});
    corr_x    = {s3_corr_r[CORR_W-1], s3_corr_r};
    left_raw  = base_x + corr_x;
    right_raw = base_x - corr_x;
    left_nxt  = clamp_pulse(left_raw, cfg.pulse_min, cfg.pulse_max);
    right_nxt = clamp_pulse(right_raw, cfg.pulse_min, cfg.pulse_max);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      integ_sum_r <= '0;
    end else if (adv) begin
      s1_vld_r  <= !q_stat.empty;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
      if (integ_upd) begin
        integ_sum_r <= integ_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_integ_r  <= pop_item.integ;
      s1_pprod_r  <= pgain_x * err_x;
      s1_iprod_r  <= igain_x * err_x;
      s2_integ_r  <= s1_integ_r;
      s2_pterm_r  <= s1_pprod_r;
      s3_integ_r  <= s2_integ_r;
      s3_corr_r   <= corr_nxt;
      out_integ_r <= s3_integ_r;
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_left_pulse  = out_left_r;
  assign out_right_pulse = out_right_r;
  assign out_integrating = out_integ_r;

  `WPDM_ASSERT(a_isum_upd, !$stable(integ_sum_r) |-> $past(integ_upd), "stray integral update")
  `WPDM_ASSERT(a_hold_in_stall, s3_vld_r && !adv |=> s3_vld_r, "pipeline lost an item while stalled")

endmodule

// File: rtl/windowed_pi_differential_motor_mix.sv
// Top level of the windowed PI controller with differential motor mix.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_pitch
//   out      output     out_valid / out_stall  out_left_pulse, out_right_pulse, out_integrating
//   cfg      input      cfg_wr_en              cfg_index, cfg_wdata
//
// One sample is accepted per cycle while in_stall is low; the rate is set by the integral accumulate stage,
// whose saturating add feeds straight back into the integral register.
// A result passes the front register, the queue, the product, integral and rounding stages and the output register.
// Reset is synchronous and active low; it restores the register defaults and clears the
// integral. An output stall on a held result freezes the back end; the two-entry queue and
// front register keep absorbing samples until full, after which in_stall rises.
module windowed_pi_differential_motor_mix (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [wpdm_pkg::ANGLE_W-1:0]   in_pitch,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [wpdm_pkg::PULSE_W-1:0]          out_left_pulse,
  output logic [wpdm_pkg::PULSE_W-1:0]          out_right_pulse,
  output logic                                  out_integrating,
  input  logic                                  cfg_wr_en,
  input  logic [wpdm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wpdm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import wpdm_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    push, pop;
  item_t   push_item, pop_item;
  q_stat_t q_stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  cfg_nxt.prop_gain    = cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg_nxt.integ_gain   = cfg_wdata[GAIN_W-1:0];
        REG_TARGET:     cfg_nxt.target_angle = $signed(cfg_wdata[ANGLE_W-1:0]);
        REG_WINDOW:     cfg_nxt.integ_window = cfg_wdata[WIN_W-1:0];
        REG_BASE:       cfg_nxt.base_pulse   = cfg_wdata[PULSE_W-1:0];
        REG_PMIN:       cfg_nxt.pulse_min    = cfg_wdata[PULSE_W-1:0];
        REG_PMAX:       cfg_nxt.pulse_max    = cfg_wdata[PULSE_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= PROP_GAIN_RST;
      cfg_r.integ_gain   <= INTEG_GAIN_RST;
      cfg_r.target_angle <= TARGET_RST;
      cfg_r.integ_window <= WINDOW_RST;
      cfg_r.base_pulse   <= BASE_RST;
      cfg_r.pulse_min    <= PMIN_RST;
      cfg_r.pulse_max    <= PMAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wpdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pitch  (in_pitch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  wpdm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  wpdm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .pop_item        (pop_item),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_pulse  (out_left_pulse),
    .out_right_pulse (out_right_pulse),
    .out_integrating (out_integrating)
  );

endmodule

// File: tb/wpdm_mix_checker.sv
// Scoreboard for the motor mix: predicts every result from accepted pitch samples and compares.
module wpdm_mix_checker
  import wpdm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] in_pitch,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [PULSE_W-1:0]        out_left_pulse,
  input  logic [PULSE_W-1:0]        out_right_pulse,
  input  logic                      out_integrating,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  output int                        mismatches,
  output int                        outstanding,
  output int                        checked
);

  typedef struct packed {
    logic [PULSE_W-1:0] left_pulse;
    logic [PULSE_W-1:0] right_pulse;
    logic               integrating;
  } mix_t;

  localparam longint SUM_HI  = (longint'(1) <<< (ISUM_W - 1)) - 1;
  localparam longint SUM_LO  = -(longint'(1) <<< (ISUM_W - 1));
  localparam longint HALF_US = longint'(1) <<< (FRAC_W - 1);

  cfg_t ctl;
  int   integ_acc;
  mix_t mix_q[$];
  int   bad_cnt  = 0;
  int   done_cnt = 0;

  function automatic logic [PULSE_W-1:0] clamp_pulse(longint p);
    if (p < longint'(ctl.pulse_min)) p = longint'(ctl.pulse_min);
    if (p > longint'(ctl.pulse_max)) p = longint'(ctl.pulse_max);
    return p[PULSE_W-1:0];
  endfunction

  // Updates the integral as the block does, then returns the mixed pulse pair.
  function automatic mix_t predict_mix(logic signed [ANGLE_W-1:0] pitch);
    longint err;
    longint mag;
    longint acc;
    longint corr;
    mix_t   res;
    err = longint'(pitch) - longint'($signed(ctl.target_angle));
    mag = (err < 0) ? -err : err;
    res.integrating = (mag < longint'(ctl.integ_window));
    if (res.integrating) begin
      acc = longint'(integ_acc) + longint'(ctl.integ_gain) * err;
      if (acc > SUM_HI) acc = SUM_HI;
      if (acc < SUM_LO) acc = SUM_LO;
      integ_acc = int'(acc);
    end
    // Arithmetic shift of the biased sum rounds half-way cases towards plus infinity.
    corr = (longint'(ctl.prop_gain) * err + longint'(integ_acc) + HALF_US) >>> FRAC_W;
    res.left_pulse  = clamp_pulse(longint'(ctl.base_pulse) + corr);
    res.right_pulse = clamp_pulse(longint'(ctl.base_pulse) - corr);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    mix_t want;
    if (!rst_n) begin
      ctl = '{prop_gain: PROP_GAIN_RST, integ_gain: INTEG_GAIN_RST, target_angle: TARGET_RST,
              integ_window: WINDOW_RST, base_pulse: BASE_RST, pulse_min: PMIN_RST,
              pulse_max: PMAX_RST};
      integ_acc = 0;
      mix_q.delete();
    end else begin
      // The result leaving now always belongs to an earlier transfer than any arriving now.
      if (out_valid && !out_stall) begin
        if (mix_q.size() == 0) begin
          $error("result transfer with no prediction pending: left %0d right %0d integ %0d",
                 out_left_pulse, out_right_pulse, out_integrating);
          bad_cnt++;
        end else begin
          want = mix_q.pop_front();
          done_cnt++;
          if (out_left_pulse !== want.left_pulse) begin
            $error("left_pulse mismatch: expected %0d, got %0d", want.left_pulse,
                   out_left_pulse);
            bad_cnt++;
          end
          if (out_right_pulse !== want.right_pulse) begin
            $error("right_pulse mismatch: expected %0d, got %0d", want.right_pulse,
                   out_right_pulse);
            bad_cnt++;
          end
          if (out_integrating !== want.integrating) begin
            $error("integrating mismatch: expected %0d, got %0d", want.integrating,
                   out_integrating);
            bad_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) mix_q.push_back(predict_mix(in_pitch));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PROP_GAIN:  ctl.prop_gain    = cfg_wdata[GAIN_W-1:0];
          REG_INTEG_GAIN: ctl.integ_gain   = cfg_wdata[GAIN_W-1:0];
          REG_TARGET:     ctl.target_angle = cfg_wdata[ANGLE_W-1:0];
          REG_WINDOW:     ctl.integ_window = cfg_wdata[WIN_W-1:0];
          REG_BASE:       ctl.base_pulse   = cfg_wdata[PULSE_W-1:0];
          REG_PMIN:       ctl.pulse_min    = cfg_wdata[PULSE_W-1:0];
          REG_PMAX:       ctl.pulse_max    = cfg_wdata[PULSE_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches  <= bad_cnt;
    checked     <= done_cnt;
    outstanding <= mix_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the motor mix testbench: clock, reset, stimulus, random stalls and the verdict.
module tb_top;
  import wpdm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int LIMIT       = 500000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 88;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] in_pitch  = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [PULSE_W-1:0]        out_left_pulse;
  logic [PULSE_W-1:0]        out_right_pulse;
  logic                      out_integrating;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_PROP_GAIN;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  logic quiet      = 1'b0;
  int   stall_hold = 0;
  int   cycles     = 0;
  int   sent       = 0;
  int   settings   = 1;
  int   mismatches;
  int   outstanding;
  int   checked;

  int first_pitches[11] = '{2304, 768, 2048, 1024, 2047, 1025, 1536, 65535, -65536, 46080,
                            -46080};
  int sat_pitches[6]    = '{65534, 65534, -65534, -65534, 0, 65535};
  int flip_pitches[3]   = '{-65536, 0, 65535};

  windowed_pi_differential_motor_mix uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pitch        (in_pitch),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_pulse  (out_left_pulse),
    .out_right_pulse (out_right_pulse),
    .out_integrating (out_integrating),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  wpdm_mix_checker mix_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pitch        (in_pitch),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_pulse  (out_left_pulse),
    .out_right_pulse (out_right_pulse),
    .out_integrating (out_integrating),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .checked         (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short pauses with the odd long one.
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_edge(int lo, int hi, int typical);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return lo;
    if (r < 30) return hi;
    return typical;
  endfunction

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      out_stall  <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall  <= 1'b1;
      stall_hold <= pause_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Holds the sample until the block takes it; the task returns on the edge of the transfer.
  task automatic send_pitch(input logic signed [ANGLE_W-1:0] p);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 50) ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_pitch <= ANGLE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pitch <= p;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Unused upper data bits are filled at random; the block must ignore them.
  task automatic apply_setting(input cfg_t s);
    put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    put_reg(REG_PROP_GAIN, {1'($urandom), s.prop_gain});
    put_reg(REG_INTEG_GAIN, {1'($urandom), s.integ_gain});
    put_reg(REG_TARGET, s.target_angle);
    put_reg(REG_WINDOW, {1'($urandom), s.integ_window});
    put_reg(REG_BASE, {5'($urandom), s.base_pulse});
    put_reg(REG_PMIN, {5'($urandom), s.pulse_min});
    put_reg(REG_PMAX, {5'($urandom), s.pulse_max});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    cfg_t s;
    int   w;
    int   r;
    int   p;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: rounding ties both ways, window edges, zero error and field extremes.
    foreach (first_pitches[i]) send_pitch(ANGLE_W'(first_pitches[i]));
    wait_idle();

    // Maximum gains and window drive the integral into both saturation limits.
    s = '{prop_gain: 16'hFFFF, integ_gain: 16'hFFFF, target_angle: '0,
          integ_window: 16'hFFFF, base_pulse: 12'hFFF, pulse_min: '0, pulse_max: 12'hFFF};
    apply_setting(s);
    foreach (sat_pitches[i]) send_pitch(ANGLE_W'(sat_pitches[i]));
    wait_idle();

    // Minimum above maximum, and a zero window that can never integrate.
    s = '{prop_gain: 16'd4096, integ_gain: '0, target_angle: 17'h0FFFF,
          integ_window: '0, base_pulse: '0, pulse_min: 12'd3000, pulse_max: 12'd200};
    apply_setting(s);
    foreach (flip_pitches[i]) send_pitch(ANGLE_W'(flip_pitches[i]));
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      s.prop_gain    = GAIN_W'(pick_edge(0, 65535, $urandom_range(0, 8191)));
      s.integ_gain   = GAIN_W'(pick_edge(0, 65535, $urandom_range(0, 1023)));
      s.target_angle = ANGLE_W'(pick_edge(-65536, 65535, int'($urandom_range(0, 6000)) - 3000));
      s.integ_window = WIN_W'(pick_edge(0, 65535, $urandom_range(0, 2048)));
      s.base_pulse   = PULSE_W'(pick_edge(0, 4095, $urandom_range(900, 1650)));
      s.pulse_min    = PULSE_W'(pick_edge(0, 4095, $urandom_range(800, 1300)));
      s.pulse_max    = PULSE_W'(pick_edge(0, 4095, $urandom_range(1250, 2000)));
      quiet <= ($urandom_range(0, 3) == 0);
      apply_setting(s);
      w = int'(s.integ_window);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        // Most samples sit around the target so that the integral is exercised.
        if (r < 45)
          p = int'($signed(s.target_angle)) + int'($urandom_range(0, 2 * w + 4)) - (w + 2);
        else if (r < 55)
          p = int'($signed(s.target_angle)) + ($urandom_range(0, 1) ? w : -w)
              + int'($urandom_range(0, 2)) - 1;
        else if (r < 85)
          p = int'($urandom_range(0, 92160)) - 46080;
        else
          p = int'($urandom);
        send_pitch(ANGLE_W'(p));
      end
      wait_idle();
    end

    $display("Checked %0d motor mix results from %0d pitch transfers under %0d settings.",
             checked, sent, settings);
    $display("Settings spanned gain, target, window and pulse limit extremes, inverted too.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/wpdm_pkg.sv
rtl/wpdm_front.sv
rtl/wpdm_queue.sv
rtl/wpdm_back.sv
rtl/windowed_pi_differential_motor_mix.sv
tb/wpdm_mix_checker.sv
tb/tb_top.sv
